[sv/sgfm_pkg.sv]
package sgfm_pkg;

    localparam int TIME_BITS   = 48;
    localparam int COUNT_BITS  = 16;
    localparam int THR_BITS    = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [THR_BITS-1:0] GAP_THRESHOLD_RESET = THR_BITS'(1000000);

    typedef enum logic [2:0] {
        OP_BYTE       = 3'd0,
        OP_MARK_START = 3'd1,
        OP_MARK_END   = 3'd2,
        OP_SESS_START = 3'd3,
        OP_SESS_STOP  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_BYTE        = 2'd0,
        KIND_AUTO_GAP    = 2'd1,
        KIND_MANUAL      = 2'd2,
        KIND_AUTO_FLUSH  = 2'd3
    } kind_t;

    // Event held in the input register.
    typedef struct packed {
        logic                 valid;
        logic [2:0]           opcode;
        logic [TIME_BITS-1:0] time_stamp;
    } event_t;

    // One result item.
    typedef struct packed {
        kind_t                  result_kind;
        logic [TIME_BITS-1:0]   frame_start;
        logic [TIME_BITS-1:0]   frame_end;
        logic [COUNT_BITS-1:0]  frame_bytes;
        logic                   gap_valid;
        logic [TIME_BITS-1:0]   frame_gap;
        logic [TIME_BITS-1:0]   byte_delta;
        logic [TIME_BITS-1:0]   min_delta;
        logic [TIME_BITS-1:0]   max_delta;
        logic [TIME_BITS-1:0]   idle_total;
        logic                   last_in_run;
    } result_t;

    // Up to two results produced by one event.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

endpackage

[sv/sgfm_in_reg.sv]
module sgfm_in_reg
    import sgfm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2:0]           s_tuser,
    input  logic [TIME_BITS-1:0] s_tdata,
    input  logic                 take,
    output event_t               ev
);

    event_t ev_reg;

    // Refill whenever the held event leaves or the register is empty.
    assign s_tready = !ev_reg.valid || take;
    assign ev       = ev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg.valid <= 1'b0;
        end else if (s_tready) begin
            ev_reg.valid <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            ev_reg.opcode     <= s_tuser;
            ev_reg.time_stamp <= s_tdata;
        end
    end

endmodule

[sv/sgfm_engine.sv]
module sgfm_engine
    import sgfm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [THR_BITS-1:0] cfg_wdata,
    input  event_t              ev,
    input  logic                take,
    output push_t               push
);

    typedef struct packed {
        logic                  running;
        logic                  have_prev;
        logic [TIME_BITS-1:0]  prev_time;
        logic                  auto_open;
        logic [TIME_BITS-1:0]  auto_start;
        logic [COUNT_BITS-1:0] auto_count;
        logic                  man_open;
        logic [TIME_BITS-1:0]  man_start;
        logic [COUNT_BITS-1:0] man_count;
        logic                  have_last;
        logic [TIME_BITS-1:0]  last_end;
        logic [TIME_BITS-1:0]  run_min;
        logic [TIME_BITS-1:0]  run_max;
        logic [TIME_BITS-1:0]  idle_sum;
    } sess_t;

    localparam sess_t SESS_CLEAR = '{
        running:    1'b0,
        have_prev:  1'b0,
        prev_time:  '0,
        auto_open:  1'b0,
        auto_start: '0,
        auto_count: '0,
        man_open:   1'b0,
        man_start:  '0,
        man_count:  '0,
        have_last:  1'b0,
        last_end:   '0,
        run_min:    '1,
        run_max:    '0,
        idle_sum:   '0
    };

    sess_t               st_reg, st_next;
    logic [THR_BITS-1:0] thr_reg;

    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] thr_ext;
    logic [TIME_BITS-1:0] delta;
    logic [TIME_BITS-1:0] excess;
    logic [TIME_BITS:0]   idle_add;
    logic                 over_gap;
    logic                 close_auto;
    push_t                p;

    function automatic result_t make_frame(
        input kind_t                 kind,
        input logic [TIME_BITS-1:0]  fstart,
        input logic [TIME_BITS-1:0]  fend,
        input logic [COUNT_BITS-1:0] bytes,
        input logic                  gv,
        input logic [TIME_BITS-1:0]  gap
    );
        result_t r;
        r             = '0;
        r.result_kind = kind;
        r.frame_start = fstart;
        r.frame_end   = fend;
        r.frame_bytes = bytes;
        r.gap_valid   = gv;
        r.frame_gap   = gv ? gap : '0;
        return r;
    endfunction

    assign t       = ev.time_stamp;
    assign thr_ext = TIME_BITS'(thr_reg);

    always_comb begin
        st_next    = st_reg;
        p          = '0;
        // only a byte carries a delta; every other event reports zero
        delta      = (opcode_t'(ev.opcode) == OP_BYTE && st_reg.have_prev
                      && t > st_reg.prev_time) ? t - st_reg.prev_time : '0;
        over_gap   = delta > thr_ext;
        excess     = delta - thr_ext;
        idle_add   = {1'b0, st_reg.idle_sum} + {1'b0, excess};
        close_auto = over_gap && st_reg.auto_open && (st_reg.auto_count != '0);

        if (take) begin
            unique case (opcode_t'(ev.opcode))
                OP_SESS_START: begin
                    if (!st_reg.running) begin
                        st_next         = SESS_CLEAR;
                        st_next.running = 1'b1;
                    end
                end
                OP_BYTE: begin
                    if (st_reg.running) begin
                        if (close_auto) begin
                            p.first = make_frame(KIND_AUTO_GAP, st_reg.auto_start,
                                                 st_reg.prev_time, st_reg.auto_count,
                                                 st_reg.have_last,
                                                 st_reg.auto_start - st_reg.last_end);
                            st_next.have_last = 1'b1;
                            st_next.last_end  = st_reg.prev_time;
                        end
                        if (close_auto || !st_reg.auto_open) begin
                            st_next.auto_open  = 1'b1;
                            st_next.auto_start = t;
                            st_next.auto_count = COUNT_BITS'(1);
                        end else begin
                            st_next.auto_count = count_inc(st_reg.auto_count);
                        end
                        if (st_reg.man_open) begin
                            st_next.man_count = count_inc(st_reg.man_count);
                        end
                        if (st_reg.have_prev) begin
                            if (delta < st_reg.run_min) st_next.run_min = delta;
                            if (delta > st_reg.run_max) st_next.run_max = delta;
                            if (over_gap) begin
                                // saturate the idle total at all ones
                                st_next.idle_sum = idle_add[TIME_BITS] ? '1
                                                   : idle_add[TIME_BITS-1:0];
                            end
                        end
                        st_next.prev_time = t;
                        st_next.have_prev = 1'b1;
                        if (close_auto) begin
                            p.count  = 2'd2;
                            p.second = '0;
                        end else begin
                            p.count = 2'd1;
                            p.first = '0;
                        end
                    end
                end
                OP_MARK_START: begin
                    if (st_reg.running) begin
                        st_next.man_open  = 1'b1;
                        st_next.man_start = t;
                        st_next.man_count = '0;
                    end
                end
                OP_MARK_END, OP_SESS_STOP: begin
                    if (st_reg.running) begin
                        if (st_reg.man_open) begin
                            p.first = make_frame(KIND_MANUAL, st_reg.man_start, t,
                                                 st_reg.man_count, st_reg.have_last,
                                                 st_reg.man_start - st_reg.last_end);
                            p.count           = 2'd1;
                            st_next.man_open  = 1'b0;
                            st_next.have_last = 1'b1;
                            st_next.last_end  = t;
                        end
                        if (opcode_t'(ev.opcode) == OP_SESS_STOP) begin
                            if (st_reg.auto_open && (st_reg.auto_count != '0)) begin
                                if (st_reg.man_open) begin
                                    p.second = make_frame(KIND_AUTO_FLUSH, st_reg.auto_start,
                                                          t, st_reg.auto_count, 1'b0, '0);
                                    p.count  = 2'd2;
                                end else begin
                                    p.first = make_frame(KIND_AUTO_FLUSH, st_reg.auto_start,
                                                         t, st_reg.auto_count, 1'b0, '0);
                                    p.count = 2'd1;
                                end
                                st_next.have_last = 1'b1;
                                st_next.last_end  = t;
                            end
                            st_next.auto_open = 1'b0;
                            st_next.running   = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end

        // statistics after the event go on every result of the run
        p.first.byte_delta  = delta;
        p.first.min_delta   = st_next.run_min;
        p.first.max_delta   = st_next.run_max;
        p.first.idle_total  = st_next.idle_sum;
        p.first.last_in_run = (p.count == 2'd1);
        p.second.byte_delta  = delta;
        p.second.min_delta   = st_next.run_min;
        p.second.max_delta   = st_next.run_max;
        p.second.idle_total  = st_next.idle_sum;
        p.second.last_in_run = 1'b1;
    end

    assign push = p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= SESS_CLEAR;
            thr_reg <= GAP_THRESHOLD_RESET;
        end else begin
            st_reg <= st_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
        end
    end

endmodule

[sv/sgfm_result_queue.sv]
module sgfm_result_queue
    import sgfm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    head_valid,
    output result_t head,
    input  logic    pop
);

    result_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QPTR_BITS-1:0] wr_ptr_plus1;
    logic                 do_pop;

    // Room for a full two-result run, regardless of this cycle's pop.
    assign room         = count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2);
    assign head_valid   = count_reg != '0;
    assign head         = entry_reg[rd_ptr_reg];
    assign do_pop       = pop && head_valid;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(push.count);
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            count_reg <= count_reg + QCNT_BITS'(push.count) - QCNT_BITS'(do_pop);
        end
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

[sv/serial_gap_framing_timing_monitor.sv]
// Timing monitor for a serial byte stream. Events enter on the s_ channel with the opcode
// in s_tuser and a 48-bit tick time stamp in s_tdata; outside a running session every
// event but session start is dropped. Each byte yields one "byte recorded" item carrying
// its delta from the previous byte and the session min, max and idle total; a byte whose
// delta exceeds the gap threshold first closes the automatic frame at the previous byte's
// time, ahead of its own item. Frame end and session stop close an open manual frame, and
// stop also flushes a non-empty automatic frame. The last item of each event has m_tlast
// set. One event is accepted per cycle while the result queue has room; an accepted event
// waits in the input register until the engine takes it, and the engine writes its items
// into the result queue. The m_ side delivers one item per cycle while m_tready is high;
// the four-entry result queue holds off input once it cannot take a two-item run.
// The gap threshold is written through cfg_we/cfg_wdata and resets to 1000000 ticks; the
// user must write it only while the block is idle; the block does not enforce this.
module serial_gap_framing_timing_monitor
    import sgfm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    // configuration: gap threshold in ticks
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata,
    // event input
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [2:0]    s_tuser,   // [2:0] opcode
    input  logic [47:0]   s_tdata,   // [47:0] time_stamp
    // result output
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [2:0]    m_tuser,   // [1:0] result_kind, [2] gap_valid
    output logic [351:0]  m_tdata,   // [47:0] frame_start, [95:48] frame_end,
                                     // [111:96] frame_bytes, [159:112] frame_gap,
                                     // [207:160] byte_delta, [255:208] min_delta,
                                     // [303:256] max_delta, [351:304] idle_total
    output logic          m_tlast    // last_in_run
);

    event_t  ev;
    push_t   push;
    result_t head;
    logic    room;
    logic    take;

    // Hand the held event to the engine only when its results are sure to fit.
    assign take = ev.valid && room;

    sgfm_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .take      (take),
        .ev        (ev)
    );

    sgfm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ev        (ev),
        .take      (take),
        .push      (push)
    );

    sgfm_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (room),
        .head_valid (m_tvalid),
        .head       (head),
        .pop        (m_tready)
    );

    // Pack the head item onto the output bus, first field lowest.
    assign m_tuser = {head.gap_valid, head.result_kind};
    assign m_tdata = {head.idle_total, head.max_delta, head.min_delta, head.byte_delta,
                      head.frame_gap, head.frame_bytes, head.frame_end, head.frame_start};
    assign m_tlast = head.last_in_run;

endmodule

[sim/tb_top.sv]
module tb_top;
    import sgfm_pkg::*;

    // Generous ceiling: many times the cycles of the whole run under the longest stalls.
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    // Event passes the input register and the result queue before the output; allow margin.
    localparam int          SETTLE_CYCLES = 16;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          RANDOM_ITEMS  = 1650;

    // Opcodes the block leaves undefined; it must drop them.
    localparam logic [2:0]  OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI  = 3'd7;
    localparam logic [47:0] TIME_MAX      = '1;

    // Tracks one session the way the block should, and keeps the result items
    // each accepted event must produce, oldest first.
    class gap_frame_tracker;
        logic [31:0] gap_thr;
        bit          running;
        bit          have_prev;
        bit          auto_open;
        bit          manual_open;
        bit          have_last;
        logic [47:0] prev_time;
        logic [47:0] auto_start;
        logic [47:0] manual_start;
        logic [47:0] last_end;
        logic [47:0] min_d;
        logic [47:0] max_d;
        logic [47:0] idle;
        logic [15:0] auto_cnt;
        logic [15:0] manual_cnt;
        result_t     results_due[$];
        int          mismatches;

        function new();
            gap_thr    = GAP_THRESHOLD_RESET;
            running    = 0;
            mismatches = 0;
            clear_session();
        endfunction

        function void clear_session();
            have_prev    = 0;
            auto_open    = 0;
            manual_open  = 0;
            have_last    = 0;
            prev_time    = '0;
            auto_start   = '0;
            manual_start = '0;
            last_end     = '0;
            auto_cnt     = '0;
            manual_cnt   = '0;
            min_d        = '1;
            max_d        = '0;
            idle         = '0;
        endfunction

        function logic [15:0] bump(logic [15:0] c);
            return (c == 16'hFFFF) ? c : c + 16'd1;
        endfunction

        // Close a frame; the gap is taken against the previous closed frame.
        function result_t close_frame(kind_t kind, logic [47:0] first_t,
                                      logic [47:0] last_t, logic [15:0] cnt,
                                      bit with_gap);
            result_t r;
            r             = '0;
            r.result_kind = kind;
            r.frame_start = first_t;
            r.frame_end   = last_t;
            r.frame_bytes = cnt;
            if (with_gap && have_last) begin
                r.gap_valid = 1'b1;
                r.frame_gap = first_t - last_end;
            end
            have_last = 1;
            last_end  = last_t;
            return r;
        endfunction

        // Returns 1 for a session start outside a session or a defined event inside one, 0 when it is dropped.
        function bit note_event(logic [2:0] op, logic [47:0] ts);
            result_t     r[2];
            int          n;
            logic [47:0] delta;
            logic [47:0] thr48;
            logic [47:0] add;
            n     = 0;
            delta = '0;
            thr48 = {16'd0, gap_thr};
            if (op == OP_SESS_START) begin
                if (running)
                    return 0;
                clear_session();
                running = 1;
                return 1;
            end
            if (!running || op > OP_SESS_STOP)
                return 0;
            case (op)
                OP_BYTE: begin
                    if (have_prev && ts > prev_time)
                        delta = ts - prev_time;
                    if (delta > thr48 && auto_open && auto_cnt != 0) begin
                        r[n] = close_frame(KIND_AUTO_GAP, auto_start, prev_time, auto_cnt, 1);
                        n++;
                        auto_open = 0;
                    end
                    if (!auto_open) begin
                        auto_open  = 1;
                        auto_start = ts;
                        auto_cnt   = '0;
                    end
                    auto_cnt = bump(auto_cnt);
                    if (manual_open)
                        manual_cnt = bump(manual_cnt);
                    if (have_prev) begin
                        if (delta < min_d)
                            min_d = delta;
                        if (delta > max_d)
                            max_d = delta;
                        if (delta > thr48) begin
                            add  = delta - thr48;
                            idle = (add > TIME_MAX - idle) ? TIME_MAX : idle + add;
                        end
                    end
                    prev_time     = ts;
                    have_prev     = 1;
                    r[n]          = '0;
                    r[n].result_kind = KIND_BYTE;
                    n++;
                end
                OP_MARK_START: begin
                    manual_open  = 1;
                    manual_start = ts;
                    manual_cnt   = '0;
                end
                default: begin
                    if (manual_open) begin
                        r[n] = close_frame(KIND_MANUAL, manual_start, ts, manual_cnt, 1);
                        n++;
                        manual_open = 0;
                    end
                    if (op == OP_SESS_STOP) begin
                        if (auto_open && auto_cnt != 0) begin
                            r[n] = close_frame(KIND_AUTO_FLUSH, auto_start, ts, auto_cnt, 0);
                            n++;
                        end
                        auto_open = 0;
                        running   = 0;
                    end
                end
            endcase
            // Session statistics are those after the whole event.
            for (int k = 0; k < n; k++) begin
                r[k].byte_delta  = delta;
                r[k].min_delta   = min_d;
                r[k].max_delta   = max_d;
                r[k].idle_total  = idle;
                r[k].last_in_run = (k == n - 1);
                results_due.push_back(r[k]);
            end
            return 1;
        endfunction

        function string show(result_t r);
            return $sformatf({"kind=%0d start=%h end=%h bytes=%0d gap_ok=%b gap=%h ",
                              "delta=%h min=%h max=%h idle=%h last=%b"},
                             r.result_kind, r.frame_start, r.frame_end, r.frame_bytes,
                             r.gap_valid, r.frame_gap, r.byte_delta, r.min_delta,
                             r.max_delta, r.idle_total, r.last_in_run);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %s", show(got));
                return;
            end
            want = results_due.pop_front();
            if (got.result_kind !== want.result_kind || got.frame_start !== want.frame_start ||
                got.frame_end   !== want.frame_end   || got.frame_bytes !== want.frame_bytes ||
                got.gap_valid   !== want.gap_valid   || got.frame_gap   !== want.frame_gap   ||
                got.byte_delta  !== want.byte_delta  || got.min_delta   !== want.min_delta   ||
                got.max_delta   !== want.max_delta   || got.idle_total  !== want.idle_total  ||
                got.last_in_run !== want.last_in_run) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch, expected %s", show(want));
                    $display("                 actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_we    = 1'b0;
    logic [31:0]   cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [2:0]    s_tuser   = '0;   // [2:0] opcode
    logic [47:0]   s_tdata   = '0;   // [47:0] time_stamp
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [2:0]    m_tuser;          // [1:0] result_kind, [2] gap_valid
    logic [351:0]  m_tdata;          // frame_start, frame_end, frame_bytes, frame_gap,
                                     // byte_delta, min_delta, max_delta, idle_total
    logic          m_tlast;          // last_in_run

    gap_frame_tracker tracker = new();
    bit               idle_en = 1'b1;   // random gaps on both sides while set
    int               handled = 0;      // events the block acts on
    int unsigned      cycle_count = 0;

    serial_gap_framing_timing_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: accept by default, stall in random bursts while idle_en is set.
    initial begin
        forever begin
            @(posedge aclk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Unpack every accepted result item and compare it with the oldest one due.
    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.result_kind = kind_t'(m_tuser[1:0]);
            got.gap_valid   = m_tuser[2];
            got.frame_start = m_tdata[47:0];
            got.frame_end   = m_tdata[95:48];
            got.frame_bytes = m_tdata[111:96];
            got.frame_gap   = m_tdata[159:112];
            got.byte_delta  = m_tdata[207:160];
            got.min_delta   = m_tdata[255:208];
            got.max_delta   = m_tdata[303:256];
            got.idle_total  = m_tdata[351:304];
            got.last_in_run = m_tlast;
            tracker.check_result(got);
        end
    end

    // Offer one event, optionally after a random gap, and hold it until taken.
    // tvalid stays high on return so back-to-back events need no dead cycle.
    task automatic send_event(logic [2:0] op, logic [47:0] ts);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ts;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (tracker.note_event(op, ts))
            handled++;
    endtask

    // Drop tvalid, wait for all due results, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && tracker.results_due.size() != 0; i++)
            @(posedge aclk);
        if (tracker.results_due.size() != 0) begin
            $display("%0d result items never arrived", tracker.results_due.size());
            tracker.mismatches++;
            tracker.results_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_threshold(logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tracker.gap_thr = value;
    endtask

    // Step between events, weighted around the threshold so frames close often.
    function automatic logic [47:0] next_step(logic [31:0] thr);
        case ($urandom_range(0, 9))
            0:          return '0;
            1, 2, 3, 4: return 48'($urandom_range(1, 64));
            5:          return {16'd0, thr};
            6:          return {16'd0, thr} + 48'd1;
            7:          return {16'd0, thr} + 48'($urandom_range(2, 5000));
            8:          return -48'($urandom_range(1, 1000));   // time going backwards
            default:    return 48'({$urandom, $urandom});
        endcase
    endfunction

    // Edge cases under the reset threshold.
    task automatic run_directed();
        send_event(OP_BYTE, 48'd5);              // dropped: no session
        send_event(OP_SESS_STOP, 48'd6);         // dropped: no session
        send_event(OP_UNUSED_HI, 48'd7);
        send_event(OP_SESS_START, 48'd0);
        send_event(OP_SESS_START, 48'd1);        // ignored while running
        send_event(OP_BYTE, 48'd0);              // first byte, delta zero
        send_event(OP_UNUSED_LO, 48'd2);
        send_event(OP_MARK_END, 48'd3);          // no manual frame open
        send_event(OP_MARK_START, 48'd10);
        send_event(OP_MARK_START, 48'd20);       // restart the manual frame
        send_event(OP_BYTE, 48'd100);
        send_event(OP_BYTE, 48'd50);             // backwards
        send_event(OP_BYTE, TIME_MAX);           // huge gap closes the auto frame
        send_event(OP_BYTE, 48'd0);
        send_event(OP_BYTE, TIME_MAX);           // idle total saturates
        send_event(OP_MARK_END, 48'd5);
        send_event(OP_MARK_START, 48'd30);
        send_event(OP_BYTE, 48'd40);
        send_event(OP_UNUSED_LO + 3'd1, 48'd45);
        send_event(OP_SESS_STOP, 48'd60);        // manual close and auto flush
        send_event(OP_SESS_START, 48'd1000);
        send_event(OP_SESS_STOP, 48'd1001);      // nothing to flush
        send_event(OP_SESS_STOP, 48'd1002);
        send_event(OP_MARK_END, 48'd1003);
    endtask

    // Mostly well-formed sessions with random timing, some stray events.
    task automatic run_random(int target);
        int          first;
        int          pick;
        logic [47:0] now;
        first = handled;
        now   = 48'({$urandom, $urandom});
        while (handled - first < target) begin
            if (!tracker.running) begin
                if ($urandom_range(0, 3) == 0)
                    now = 48'({$urandom, $urandom});
                if ($urandom_range(0, 7) == 0)
                    send_event(3'($urandom_range(OP_BYTE, OP_UNUSED_HI)), now);
                else
                    send_event(OP_SESS_START, now);
            end else begin
                pick = $urandom_range(0, 99);
                now  = now + next_step(tracker.gap_thr);
                if (pick < 68)
                    send_event(OP_BYTE, now);
                else if (pick < 76)
                    send_event(OP_MARK_START, now);
                else if (pick < 84)
                    send_event(OP_MARK_END, now);
                else if (pick < 88)
                    send_event(OP_SESS_STOP, now);
                else if (pick < 94)
                    send_event(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), now);
                else
                    send_event(3'($urandom_range(OP_BYTE, OP_UNUSED_HI)),
                               48'({$urandom, $urandom}));
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] thresholds[6];
        thresholds = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd250, 32'd5000, $urandom};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        drain();

        // One phase per threshold; the final phase runs without idling.
        for (int k = 0; k < 6; k++) begin
            load_threshold(thresholds[k]);
            if (k == 5)
                idle_en = 1'b0;
            run_random(RANDOM_ITEMS / 6);
            drain();
        end

        if (tracker.mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
